// ===== src/obre_pkg.sv =====
// Shared constants and types for the occupancy bitmap rectangle engine.
`timescale 1ns / 1ps

package obre_pkg;

  localparam int MAP_SIDE_MAX = 512;
  localparam int ADDR_W = $clog2(MAP_SIDE_MAX);
  localparam int COORD_W = 13;
  localparam int SIDE_REG_W = 10;
  localparam int POS_W = 11;
  localparam int SIZE_W = 8;
  localparam int FUNC_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [SIDE_REG_W-1:0] MAP_RESET_SIDE = SIDE_REG_W'(240 << 1);

  localparam logic [FUNC_W-1:0] FUNC_SET = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TEST = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR_ALL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [MAP_SIDE_MAX-1:0] col_word_t;
  typedef logic [ADDR_W-1:0] col_addr_t;

endpackage

// ===== src/obre_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module obre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/occupancy_bitmap_rect_engine.sv =====
// Top level of the occupancy bitmap rectangle engine: control, bounds logic and map RAM.
`timescale 1ns / 1ps

// A set, clear or test steps through the bounds, mask and walk states and shows its result
// from the last state; an empty rectangle or an out-of-map test answers from the mask
// state, and a whole-map clear at the end of its clearing pass.
// Throughput: one column per cycle; the next command is taken in the cycle its result is shown.
// Reset: rst runs a clearing pass over all MAP_SIDE_MAX columns, one column per cycle, with busy
// high; results are strobed on done for one cycle and the receiver cannot stall them.
module occupancy_bitmap_rect_engine (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [obre_pkg::FUNC_W-1:0]            func,
  input  logic signed [obre_pkg::POS_W-1:0]      pos_x,
  input  logic signed [obre_pkg::POS_W-1:0]      pos_y,
  input  logic [obre_pkg::SIZE_W-1:0]            size_x,
  input  logic [obre_pkg::SIZE_W-1:0]            size_y,
  input  logic                                   cfg_we,
  input  logic [obre_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [obre_pkg::SIDE_REG_W-1:0]        cfg_data,
  output logic                                   busy,
  output logic                                   done,
  output logic                                   occupied
);

  // Controller states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_BOUND = 3'd2;
  localparam logic [2:0] S_MASK  = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_LAST  = 3'd5;

  localparam obre_pkg::col_addr_t LAST_COL = obre_pkg::ADDR_W'(obre_pkg::MAP_SIDE_MAX - 1);

  logic [2:0] state;

  // Configuration registers.
  logic [obre_pkg::SIDE_REG_W-1:0] map_width;
  logic [obre_pkg::SIDE_REG_W-1:0] map_height;

  // Command captured at the start transfer.
  logic [obre_pkg::FUNC_W-1:0] func_r;
  obre_pkg::coord_t px_r, py_r, sx_r, sy_r;

  // Clipped bounds, taken in the bounds cycle.
  obre_pkg::col_addr_t x_last_r;
  obre_pkg::coord_t    y_lo_r, y_hi_r;
  logic                empty_r, oob_r;

  obre_pkg::col_word_t mask;
  obre_pkg::col_addr_t col;
  logic                rd_pend;
  obre_pkg::col_addr_t rd_col;
  logic                hit;
  obre_pkg::col_addr_t clr_addr;
  logic                clr_cmd;

  // Bounds logic.
  obre_pkg::coord_t w_eff, h_eff, px_end, py_end;
  obre_pkg::coord_t x_lo, x_hi, x_hi_m1, y_lo, y_hi;
  logic             empty, oob;
  obre_pkg::col_word_t mask_next;

  // RAM ports.
  logic                ram_we;
  obre_pkg::col_addr_t ram_waddr;
  obre_pkg::col_word_t ram_wdata;
  obre_pkg::col_word_t ram_rdata;
  logic                rd_hit;

  assign busy = (state != S_IDLE);

  // A map register above the store side acts as the store side.
  always_comb begin
    w_eff = (obre_pkg::COORD_W'(map_width) > obre_pkg::COORD_W'(obre_pkg::MAP_SIDE_MAX))
            ? obre_pkg::COORD_W'(obre_pkg::MAP_SIDE_MAX) : obre_pkg::COORD_W'(map_width);
    h_eff = (obre_pkg::COORD_W'(map_height) > obre_pkg::COORD_W'(obre_pkg::MAP_SIDE_MAX))
            ? obre_pkg::COORD_W'(obre_pkg::MAP_SIDE_MAX) : obre_pkg::COORD_W'(map_height);
    px_end = px_r + sx_r;
    py_end = py_r + sy_r;
    x_lo = (px_r < 0) ? '0 : px_r;
    y_lo = (py_r < 0) ? '0 : py_r;
    x_hi = (px_end < w_eff) ? px_end : w_eff;
    y_hi = (py_end < h_eff) ? py_end : h_eff;
    x_hi_m1 = x_hi - obre_pkg::COORD_W'(1);
    empty = (x_lo >= x_hi) || (y_lo >= y_hi);
    // A test of a non-empty rectangle that reaches past any map edge is occupied.
    oob = (sx_r != 0) && (sy_r != 0) &&
          ((px_r < 0) || (px_end > w_eff) || (py_r < 0) || (py_end > h_eff));
  end

  // Row mask of the clipped rectangle; each bit compares its own row index.
  always_comb begin
    for (int i = 0; i < obre_pkg::MAP_SIDE_MAX; i++) begin
      mask_next[i] = ($signed(obre_pkg::COORD_W'(i)) >= y_lo_r) &&
                     ($signed(obre_pkg::COORD_W'(i)) < y_hi_r);
    end
  end

  assign rd_hit = |(ram_rdata & mask);

  // The clearing pass writes zeros; otherwise a returning read is merged and written back unless the command is a test.
  always_comb begin
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we = rd_pend && (func_r != obre_pkg::FUNC_TEST);
      ram_waddr = rd_col;
      ram_wdata = (func_r == obre_pkg::FUNC_SET) ? (ram_rdata | mask) : (ram_rdata & ~mask);
    end
  end

  obre_ram #(
    .WIDTH(obre_pkg::MAP_SIDE_MAX),
    .DEPTH(obre_pkg::MAP_SIDE_MAX)
  ) u_map_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(col),
    .rdata(ram_rdata)
  );

  // Configuration writes are accepted in any cycle out of reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width <= obre_pkg::MAP_RESET_SIDE;
      map_height <= obre_pkg::MAP_RESET_SIDE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        obre_pkg::REG_MAP_WIDTH:  map_width <= cfg_data;
        obre_pkg::REG_MAP_HEIGHT: map_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Payload registers of the walk.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      func_r <= func;
      px_r <= obre_pkg::COORD_W'(pos_x);
      py_r <= obre_pkg::COORD_W'(pos_y);
      sx_r <= $signed(obre_pkg::COORD_W'(size_x));
      sy_r <= $signed(obre_pkg::COORD_W'(size_y));
    end
    if (state == S_BOUND) begin
      col <= x_lo[obre_pkg::ADDR_W-1:0];
      x_last_r <= x_hi_m1[obre_pkg::ADDR_W-1:0];
      y_lo_r <= y_lo;
      y_hi_r <= y_hi;
      empty_r <= empty;
      oob_r <= oob;
    end else if (state == S_WALK) begin
      col <= col + obre_pkg::ADDR_W'(1);
    end
    if (state == S_MASK) begin
      mask <= mask_next;
    end
    rd_col <= col;
    if (state == S_MASK) begin
      hit <= 1'b0;
    end else if (rd_pend) begin
      hit <= hit | rd_hit;
    end
  end

  // Controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      clr_cmd <= 1'b0;
      rd_pend <= 1'b0;
      done <= 1'b0;
      occupied <= 1'b0;
    end else begin
      done <= 1'b0;
      rd_pend <= (state == S_WALK);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (func == obre_pkg::FUNC_CLEAR_ALL) begin
              state <= S_CLEAR;
              clr_addr <= '0;
              clr_cmd <= 1'b1;
            end else begin
              state <= S_BOUND;
            end
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + obre_pkg::ADDR_W'(1);
          if (clr_addr == LAST_COL) begin
            state <= S_IDLE;
            done <= clr_cmd;
            occupied <= 1'b0;
          end
        end
        S_BOUND: begin
          state <= S_MASK;
        end
        S_MASK: begin
          if (func_r == obre_pkg::FUNC_TEST && oob_r) begin
            state <= S_IDLE;
            done <= 1'b1;
            occupied <= 1'b1;
          end else if (empty_r) begin
            state <= S_IDLE;
            done <= 1'b1;
            occupied <= 1'b0;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (col == x_last_r) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= S_IDLE;
          done <= 1'b1;
          occupied <= (func_r == obre_pkg::FUNC_TEST) && (hit || rd_hit);
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result is only shown when the controller has returned to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a command is still in progress");

  // Only a test can report an occupied rectangle.
  a_occ_test: assert property (@(posedge clk) disable iff (rst)
    (done && occupied) |-> (func_r == obre_pkg::FUNC_TEST))
    else $error("occupied reported for a command that is not a test");

  // During the walk, the write-back never targets the column being read in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == S_WALK) |-> (ram_waddr != col))
    else $error("read and write-back hit the same column");

  // Reset always starts the clearing pass.
  a_reset_clear: assert property (@(posedge clk) $past(rst) |-> (state == S_CLEAR))
    else $error("clearing pass did not start after reset");

  // A start transfer always begins work.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("start transfer did not make the engine busy");

endmodule
